>>> src/framed_packet_crc8_checker_top_macros.svh
// Assertion macros for the framed packet checker.
// Define NO_ASSERTIONS to compile them out.
`ifndef FRAMED_PACKET_CRC8_CHECKER_TOP_MACROS_SVH
`define FRAMED_PACKET_CRC8_CHECKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FPCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpcc assertion failed");
// next-cycle implication
`define FPCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpcc assertion failed");
`else
`define FPCC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FPCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/fpcc_pkg.sv
`timescale 1ns / 1ps
package fpcc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 64;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HEAD  = 3'd1;
    localparam logic [2:0] ST_TAIL  = 3'd2;
    localparam logic [2:0] ST_CRC   = 3'd3;
    localparam logic [2:0] ST_SHORT = 3'd4;

    localparam logic REG_HEAD = 1'b0;
    localparam logic REG_TAIL = 1'b1;

    // CRC-8, MSB first, one byte folded in
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/fpcc_if.sv
`timescale 1ns / 1ps
// Input beat channel: one frame byte per beat
interface fpcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_end, input ready);
    modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// Result beat channel: one beat per frame
interface fpcc_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] pkt_type;
    logic       values_updated;
    logic [7:0] sensor_first;
    logic [7:0] sensor_second;

    modport source (output valid, output status, output pkt_type, output values_updated,
                    output sensor_first, output sensor_second, input ready);
    modport sink   (input valid, input status, input pkt_type, input values_updated,
                    input sensor_first, input sensor_second, output ready);
endinterface

>>> src/framed_packet_crc8_checker_top.sv
`timescale 1ns / 1ps
// A result beat becomes valid in the cycle after the frame_end byte is accepted.
// Throughput: one byte per cycle unless a result beat waits on the sink; the byte
//   CRC update is a single unrolled 8-bit fold between the per-frame state registers,
//   and the result register frees itself in the cycle the sink takes the beat.
// Reset (i_rst_n low at a clock edge): clears head/tail registers, frame state,
//   stored sensor values and the result valid flag.
`include "framed_packet_crc8_checker_top_macros.svh"

module framed_packet_crc8_checker_top
    import fpcc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpcc_in_if.sink     i_in,
    fpcc_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES - 1);

    // config registers
    logic [7:0] r_head, r_tail;

    // per-frame state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_crc, n_crc;
    logic [7:0]       r_held, n_held;
    logic             r_head_ok, n_head_ok;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_val0, n_val0;
    logic [7:0]       r_val1, n_val1;

    // stored sensors, shown directly on the result beat
    logic [7:0] r_sens0, n_sens0;
    logic [7:0] r_sens1, n_sens1;

    // result register
    logic       r_out_valid, n_out_valid;
    logic [2:0] r_status, n_status;
    logic [7:0] r_pkt_type, n_pkt_type;
    logic       r_upd, n_upd;

    logic       w_acc;
    logic       w_cfg_wr;
    logic [7:0] w_type;
    logic [2:0] w_status;
    logic       w_store;

    // ------------------------------------------------------------------
    // APB config: register index is paddr[2], writes on the access phase
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = {24'd0, (paddr[2] == REG_TAIL) ? r_tail : r_head};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 8'd0;
            r_tail <= 8'd0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_HEAD) begin
                r_head <= pwdata[7:0];
            end else begin
                r_tail <= pwdata[7:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake: take a byte whenever the result register is free or
    // being drained this cycle.
    // ------------------------------------------------------------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;

    // Type byte: on a 4-byte frame it is the last byte itself.
    always_comb begin
        if (r_pos == POS_W'(3)) begin
            w_type = i_in.rx_byte;
        end else if (r_pos > POS_W'(3)) begin
            w_type = r_type;
        end else begin
            w_type = 8'd0;
        end
    end

    // Check order: short, head, tail, crc.
    always_comb begin
        if (r_pos < POS_W'(2)) begin
            w_status = ST_SHORT;
        end else if (!r_head_ok) begin
            w_status = ST_HEAD;
        end else if (i_in.rx_byte != r_tail) begin
            w_status = ST_TAIL;
        end else if (r_held != r_crc) begin
            w_status = ST_CRC;
        end else begin
            w_status = ST_OK;
        end
    end

    assign w_store = (w_status == ST_OK) && (w_type == 8'd0);

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_held      = r_held;
        n_head_ok   = r_head_ok;
        n_type      = r_type;
        n_val0      = r_val0;
        n_val1      = r_val1;
        n_sens0     = r_sens0;
        n_sens1     = r_sens1;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_pkt_type  = r_pkt_type;
        n_upd       = r_upd;

        if (w_acc) begin
            if (i_in.frame_end) begin
                // sensor bytes only count if they were received
                if (w_store && (r_pos > POS_W'(5))) begin
                    n_sens0 = r_val0;
                end
                if (w_store && (r_pos > POS_W'(6))) begin
                    n_sens1 = r_val1;
                end
                n_out_valid = 1'b1;
                n_status    = w_status;
                n_pkt_type  = w_type;
                n_upd       = w_store && (r_pos > POS_W'(5));
                // frame done: back to an empty frame
                n_pos       = '0;
                n_crc       = 8'd0;
                n_held      = 8'd0;
                n_head_ok   = 1'b0;
                n_type      = 8'd0;
                n_val0      = 8'd0;
                n_val1      = 8'd0;
            end else begin
                if (r_pos == POS_W'(0)) begin
                    n_head_ok = (i_in.rx_byte == r_head);
                end
                if (r_pos == POS_W'(3)) begin
                    n_type = i_in.rx_byte;
                end
                if (r_pos == POS_W'(5)) begin
                    n_val0 = i_in.rx_byte;
                end
                if (r_pos == POS_W'(6)) begin
                    n_val1 = i_in.rx_byte;
                end
                // CRC lags one byte: the held byte may be the checksum
                if (r_pos >= POS_W'(2)) begin
                    n_crc = crc8_fold(r_crc, r_held);
                end
                n_held = i_in.rx_byte;
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= 8'd0;
            r_held      <= 8'd0;
            r_head_ok   <= 1'b0;
            r_type      <= 8'd0;
            r_val0      <= 8'd0;
            r_val1      <= 8'd0;
            r_sens0     <= 8'd0;
            r_sens1     <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_held      <= n_held;
            r_head_ok   <= n_head_ok;
            r_type      <= n_type;
            r_val0      <= n_val0;
            r_val1      <= n_val1;
            r_sens0     <= n_sens0;
            r_sens1     <= n_sens1;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_pkt_type <= n_pkt_type;
        r_upd      <= n_upd;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.pkt_type       = r_pkt_type;
    assign o_out.values_updated = r_upd;
    assign o_out.sensor_first   = r_sens0;
    assign o_out.sensor_second  = r_sens1;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FPCC_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, w_acc && i_in.frame_end, r_out_valid)
    `FPCC_ASSERT_NEXT(a_end_clears_pos, i_clk, i_rst_n, w_acc && i_in.frame_end, r_pos == '0)
    `FPCC_ASSERT_NOW(a_upd_only_ok, i_clk, i_rst_n, r_out_valid && r_upd,
                     (r_status == ST_OK) && (r_pkt_type == 8'd0))
    `FPCC_ASSERT_NOW(a_status_range, i_clk, i_rst_n, r_out_valid,
                     (r_status == ST_OK) || (r_status == ST_HEAD) || (r_status == ST_TAIL) ||
                     (r_status == ST_CRC) || (r_status == ST_SHORT))

endmodule
